// ===== rtl/kvp_pkg.sv =====
package kvp_pkg;

    localparam int LINE_MAX   = 1024;
    localparam int KEY_MAX    = 64;
    localparam int LINE_LEN_W = $clog2(LINE_MAX + 1);
    localparam int KEY_LEN_W  = $clog2(KEY_MAX + 1);
    localparam int KEY_ADDR_W = $clog2(KEY_MAX);
    localparam int VLEN_W     = 21;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int SIZE_LIMIT = 2147483647;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_K     = 8'h6B;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_Y     = 8'h79;

    // register indexes of the configuration port
    localparam logic [3:0] REG_BYPASS = 4'd0;
    localparam logic [3:0] REG_VLEN   = 4'd1;

    typedef enum logic [1:0] {
        KIND_VALUE  = 2'd0,
        KIND_STORED = 2'd1,
        KIND_ERROR  = 2'd2
    } reply_kind_t;

    typedef enum logic [2:0] {
        CMD_KEY    = 3'd0,
        CMD_EMPTY  = 3'd1,
        CMD_BYPASS = 3'd2,
        CMD_STORED = 3'd3,
        CMD_ERROR  = 3'd4
    } reply_cmd_t;

    typedef struct packed {
        reply_cmd_t            cmd;
        logic [KEY_LEN_W-1:0]  key_len;
    } q_entry_t;

    typedef struct packed {
        logic                  en;
        logic [KEY_ADDR_W-1:0] addr;
        logic [7:0]            data;
    } key_wr_t;

endpackage

// ===== rtl/kvp_fifo.sv =====
module kvp_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  kvp_pkg::q_entry_t  push_data,
    output logic               full,
    input  logic               pop,
    output kvp_pkg::q_entry_t  pop_data,
    output logic               empty
);

    kvp_pkg::q_entry_t                 entry_reg [kvp_pkg::QDEPTH];
    logic [kvp_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [kvp_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [kvp_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                              do_push, do_pop;

    assign full     = (count_reg == kvp_pkg::QCNT_W'(kvp_pkg::QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == kvp_pkg::QPTR_W'(kvp_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == kvp_pkg::QPTR_W'(kvp_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/kvp_front.sv =====
module kvp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               bypass,
    output logic               q_push,
    output kvp_pkg::q_entry_t  q_push_data,
    input  logic               q_full,
    output kvp_pkg::key_wr_t   key_wr,
    input  logic               key_done
);

    typedef enum logic [2:0] {
        MODE_LINE    = 3'b001,
        MODE_SWALLOW = 3'b010,
        MODE_DROP    = 3'b100
    } mode_t;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_GET   = 2'd1,
        CLS_SET   = 2'd2,
        CLS_OTHER = 2'd3
    } class_t;

    typedef struct packed {
        logic [2:0]  idx;
        logic [3:0]  status;
        logic [30:0] acc;
        logic        cont;
    } set_scan_t;

    localparam logic [2:0] TOK_DONE = 3'd5;
    localparam logic [2:0] TOK_FAIL = 3'd6;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == kvp_pkg::CH_SP) || (b == kvp_pkg::CH_TAB) || (b == kvp_pkg::CH_LF) ||
               (b == kvp_pkg::CH_VT) || (b == kvp_pkg::CH_FF) || (b == kvp_pkg::CH_CR);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= kvp_pkg::CH_UA && b <= kvp_pkg::CH_UZ) ? b + 8'd32 : b;
    endfunction

    // One pass of the "word word int int int" scanner; cont asks for a
    // second pass on the same byte after an integer ends.
    function automatic set_scan_t set_pass(input set_scan_t s, input logic [7:0] b);
        set_scan_t   r;
        logic [1:0]  sub;
        logic        dig;
        logic        ws;
        logic [7:0]  d;
        logic [34:0] v;
        logic        take_digit;
        r          = s;
        r.cont     = 1'b0;
        sub        = s.status[1:0];
        dig        = (b >= kvp_pkg::CH_0) && (b <= kvp_pkg::CH_9);
        ws         = is_ws(b);
        d          = b - kvp_pkg::CH_0;
        v          = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {27'd0, d};
        take_digit = 1'b0;
        if (s.idx < TOK_DONE)
        begin
            if (s.idx < 3'd2)
            begin
                if (sub == 2'd0)
                begin
                    if (!ws)
                    begin
                        r.status = 4'd1;
                    end
                end
                else if (ws)
                begin
                    r.idx    = s.idx + 3'd1;
                    r.status = 4'd0;
                end
            end
            else if (sub == 2'd3 && !dig)
            begin
                r.idx    = s.idx + 3'd1;
                r.status = 4'd0;
                r.cont   = (s.idx + 3'd1) < TOK_DONE;
            end
            else if (sub == 2'd0)
            begin
                if (!ws)
                begin
                    if (b == kvp_pkg::CH_PLUS || b == kvp_pkg::CH_MINUS)
                    begin
                        r.status = {1'b0, b == kvp_pkg::CH_MINUS, 2'b10};
                    end
                    else if (!dig)
                    begin
                        r.idx = TOK_FAIL;
                    end
                    else
                    begin
                        take_digit = 1'b1;
                    end
                end
            end
            else if (sub == 2'd2 && !dig)
            begin
                r.idx = TOK_FAIL;
            end
            else
            begin
                take_digit = 1'b1;
            end
            if (take_digit)
            begin
                r.status = {s.status[3:2], 2'b11};
                if (s.idx == 3'd4 && !s.status[3])
                begin
                    if (v > 35'(kvp_pkg::SIZE_LIMIT))
                    begin
                        r.status[3] = 1'b1;
                    end
                    else
                    begin
                        r.acc = v[30:0];
                    end
                end
            end
        end
        return r;
    endfunction

    mode_t                          mode_reg, mode_next;
    logic [kvp_pkg::LINE_LEN_W-1:0] line_len_reg, line_len_next;
    logic                           pending_cr_reg, pending_cr_next;
    class_t                         class_reg, class_next;
    logic [1:0]                     prefix_reg, prefix_next;
    logic [2:0]                     tok_idx_reg, tok_idx_next;
    logic [3:0]                     tok_stat_reg, tok_stat_next;
    logic [kvp_pkg::KEY_LEN_W-1:0]  key_len_reg, key_len_next;
    logic [30:0]                    size_acc_reg, size_acc_next;
    logic [31:0]                    swallow_reg, swallow_next;
    logic                           hold_reg, hold_next;
    logic [7:0]                     hold_byte_reg, hold_byte_next;
    logic                           key_busy_reg, key_busy_next;

    logic                           accept;
    logic                           cmt_en;
    logic [7:0]                     cmt_byte;
    logic                           clr;
    logic                           get_ok;
    logic                           set_ok;
    logic [7:0]                     lc;
    class_t                         cls;
    set_scan_t                      p0, p1, p2;

    // a byte held after a lone CR is committed in the cycle after its transaction
    assign s_tready = !hold_reg && !key_busy_reg && !q_full;
    assign accept   = s_tvalid && s_tready;

    assign get_ok = (prefix_reg == 2'd3) && (class_reg == CLS_GET) && (tok_stat_reg >= 4'd2);
    assign set_ok = (prefix_reg == 2'd3) && (class_reg == CLS_SET) &&
                    ((tok_idx_reg == TOK_DONE) ||
                     (tok_idx_reg == 3'd4 && tok_stat_reg[1:0] == 2'b11)) &&
                    !tok_stat_reg[3] && (!tok_stat_reg[2] || size_acc_reg == '0);

    always_comb
    begin
        mode_next       = mode_reg;
        line_len_next   = line_len_reg;
        pending_cr_next = pending_cr_reg;
        class_next      = class_reg;
        prefix_next     = prefix_reg;
        tok_idx_next    = tok_idx_reg;
        tok_stat_next   = tok_stat_reg;
        key_len_next    = key_len_reg;
        size_acc_next   = size_acc_reg;
        swallow_next    = swallow_reg;
        hold_next       = 1'b0;
        hold_byte_next  = hold_byte_reg;
        key_busy_next   = key_busy_reg && !key_done;
        q_push          = 1'b0;
        q_push_data     = '{cmd: kvp_pkg::CMD_ERROR, key_len: '0};
        cmt_en          = 1'b0;
        cmt_byte        = s_tdata;
        clr             = 1'b0;
        lc              = to_lower(cmt_byte);
        cls             = class_reg;
        p0              = '{idx: tok_idx_reg, status: tok_stat_reg, acc: size_acc_reg,
                            cont: 1'b0};
        p1              = p0;
        p2              = p0;

        if (hold_reg)
        begin
            cmt_en   = 1'b1;
            cmt_byte = hold_byte_reg;
        end
        else if (accept)
        begin
            if (bypass)
            begin
                clr = 1'b1;
                if (pending_cr_reg && s_tdata == kvp_pkg::CH_LF)
                begin
                    pending_cr_next = 1'b0;
                    q_push          = 1'b1;
                    q_push_data.cmd = kvp_pkg::CMD_BYPASS;
                end
                else
                begin
                    pending_cr_next = (s_tdata == kvp_pkg::CH_CR);
                end
            end
            else if (mode_reg == MODE_SWALLOW)
            begin
                pending_cr_next = 1'b0;
                if (swallow_reg > 32'd1)
                begin
                    swallow_next = swallow_reg - 32'd1;
                end
                else
                begin
                    swallow_next    = '0;
                    mode_next       = MODE_LINE;
                    clr             = 1'b1;
                    q_push          = 1'b1;
                    q_push_data.cmd = kvp_pkg::CMD_STORED;
                end
            end
            else if (pending_cr_reg)
            begin
                if (s_tdata == kvp_pkg::CH_LF)
                begin
                    pending_cr_next = 1'b0;
                    clr             = 1'b1;
                    if (mode_reg == MODE_DROP)
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (get_ok)
                    begin
                        q_push = 1'b1;
                        if (key_len_reg == '0)
                        begin
                            q_push_data.cmd = kvp_pkg::CMD_EMPTY;
                        end
                        else
                        begin
                            q_push_data.cmd     = kvp_pkg::CMD_KEY;
                            q_push_data.key_len = key_len_reg;
                            key_busy_next       = 1'b1;
                        end
                    end
                    else if (set_ok)
                    begin
                        swallow_next = {1'b0, size_acc_reg} + 32'd2;
                        mode_next    = MODE_SWALLOW;
                    end
                    else
                    begin
                        q_push = 1'b1;
                    end
                end
                else
                begin
                    // the held CR is a line byte; a following non-CR byte is held and committed next cycle
                    cmt_en   = 1'b1;
                    cmt_byte = kvp_pkg::CH_CR;
                    if (s_tdata != kvp_pkg::CH_CR)
                    begin
                        pending_cr_next = 1'b0;
                        hold_next       = 1'b1;
                        hold_byte_next  = s_tdata;
                    end
                end
            end
            else if (s_tdata == kvp_pkg::CH_CR)
            begin
                pending_cr_next = 1'b1;
            end
            else
            begin
                cmt_en   = 1'b1;
                cmt_byte = s_tdata;
            end
        end

        key_wr = '{en: 1'b0, addr: key_len_reg[kvp_pkg::KEY_ADDR_W-1:0], data: cmt_byte};

        if (cmt_en && mode_reg == MODE_LINE)
        begin
            if (line_len_reg >= kvp_pkg::LINE_LEN_W'(kvp_pkg::LINE_MAX))
            begin
                mode_next = MODE_DROP;
            end
            else
            begin
                line_len_next = line_len_reg + 1'b1;
                lc            = to_lower(cmt_byte);
                if (line_len_reg < kvp_pkg::LINE_LEN_W'(3) && class_reg != CLS_OTHER)
                begin
                    if (line_len_reg == '0)
                    begin
                        cls = (lc == kvp_pkg::CH_G) ? CLS_GET :
                              (lc == kvp_pkg::CH_S) ? CLS_SET : CLS_OTHER;
                    end
                    else if (lc != ((line_len_reg == kvp_pkg::LINE_LEN_W'(1)) ?
                                    kvp_pkg::CH_E : kvp_pkg::CH_T))
                    begin
                        // "get" and "set" share their second and third letters
                        cls = CLS_OTHER;
                    end
                    if (cls != CLS_OTHER)
                    begin
                        prefix_next = prefix_reg + 2'd1;
                    end
                end
                class_next = cls;
                if (cls == CLS_GET)
                begin
                    case (tok_stat_reg) inside
                        4'd0:
                        begin
                            if (cmt_byte == kvp_pkg::CH_SP)
                            begin
                                tok_stat_next = 4'd1;
                            end
                        end
                        4'd1, 4'd2:
                        begin
                            if (cmt_byte == kvp_pkg::CH_SP)
                            begin
                                tok_stat_next = 4'd3;
                            end
                            else
                            begin
                                tok_stat_next = 4'd2;
                                if (key_len_reg < kvp_pkg::KEY_LEN_W'(kvp_pkg::KEY_MAX))
                                begin
                                    key_wr.en    = 1'b1;
                                    key_len_next = key_len_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (cls == CLS_SET)
                begin
                    p1            = set_pass(p0, cmt_byte);
                    p2            = set_pass(p1, cmt_byte);
                    tok_idx_next  = p1.cont ? p2.idx : p1.idx;
                    tok_stat_next = p1.cont ? p2.status : p1.status;
                    size_acc_next = p1.cont ? p2.acc : p1.acc;
                end
            end
        end

        if (clr)
        begin
            line_len_next = '0;
            class_next    = CLS_NONE;
            prefix_next   = '0;
            tok_idx_next  = '0;
            tok_stat_next = '0;
            key_len_next  = '0;
            size_acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_LINE;
            line_len_reg   <= '0;
            pending_cr_reg <= 1'b0;
            class_reg      <= CLS_NONE;
            prefix_reg     <= '0;
            tok_idx_reg    <= '0;
            tok_stat_reg   <= '0;
            key_len_reg    <= '0;
            size_acc_reg   <= '0;
            swallow_reg    <= '0;
            hold_reg       <= 1'b0;
            key_busy_reg   <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            line_len_reg   <= line_len_next;
            pending_cr_reg <= pending_cr_next;
            class_reg      <= class_next;
            prefix_reg     <= prefix_next;
            tok_idx_reg    <= tok_idx_next;
            tok_stat_reg   <= tok_stat_next;
            key_len_reg    <= key_len_next;
            size_acc_reg   <= size_acc_next;
            swallow_reg    <= swallow_next;
            hold_reg       <= hold_next;
            key_busy_reg   <= key_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_byte_reg <= hold_byte_next;
    end

`ifndef ASSERT_OFF
    a_no_key_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        key_busy_reg |-> !key_wr.en)
        else $error("key store written while a key reply is being read");

    a_swallow_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_SWALLOW) |-> (swallow_reg != '0))
        else $error("swallow mode with zero byte count");

    a_hold_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg |=> !hold_reg)
        else $error("held byte not committed in one cycle");
`endif

endmodule

// ===== rtl/kvp_back.sv =====
module kvp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  kvp_pkg::q_entry_t           q_data,
    output logic                        q_pop,
    input  logic [kvp_pkg::VLEN_W-1:0]  value_length,
    input  kvp_pkg::key_wr_t            key_wr,
    output logic                        key_done,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // key_byte[7:0], key_present, reply_length[20:0]
    output logic [1:0]                  m_tuser,   // reply_kind
    output logic                        m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_KEY  = 3'b010,
        ST_BYP  = 3'b100
    } state_t;

    logic [7:0]                     key_mem [kvp_pkg::KEY_MAX];
    logic [7:0]                     rdata_reg;
    logic [kvp_pkg::KEY_ADDR_W-1:0] rd_addr;

    state_t                         state_reg, state_next;
    logic [kvp_pkg::KEY_ADDR_W-1:0] idx_reg, idx_next;
    logic [kvp_pkg::KEY_LEN_W-1:0]  len_reg, len_next;
    logic                           out_valid_reg;

    kvp_pkg::reply_kind_t           out_kind_reg;
    logic [7:0]                     out_byte_reg;
    logic                           out_pres_reg;
    logic [kvp_pkg::VLEN_W-1:0]     out_len_reg;
    logic                           out_last_reg;

    logic                           load_ok;
    logic                           ld;
    kvp_pkg::reply_kind_t           ld_kind;
    logic [7:0]                     ld_byte;
    logic                           ld_pres;
    logic [kvp_pkg::VLEN_W-1:0]     ld_len;
    logic                           ld_last;
    logic                           key_last;

    assign load_ok  = !out_valid_reg || m_tready;
    assign key_last = ({1'b0, idx_reg} + kvp_pkg::KEY_LEN_W'(1)) == len_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        q_pop      = 1'b0;
        key_done   = 1'b0;
        rd_addr    = idx_reg;
        ld         = 1'b0;
        ld_kind    = kvp_pkg::KIND_VALUE;
        ld_byte    = 8'd0;
        ld_pres    = 1'b0;
        ld_len     = value_length;
        ld_last    = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && load_ok)
                begin
                    q_pop = 1'b1;
                    case (q_data.cmd)
                        kvp_pkg::CMD_KEY:
                        begin
                            state_next = ST_KEY;
                            idx_next   = '0;
                            len_next   = q_data.key_len;
                            rd_addr    = '0;
                        end
                        kvp_pkg::CMD_EMPTY:
                        begin
                            ld = 1'b1;
                        end
                        kvp_pkg::CMD_BYPASS:
                        begin
                            ld         = 1'b1;
                            ld_byte    = kvp_pkg::CH_K;
                            ld_pres    = 1'b1;
                            ld_last    = 1'b0;
                            state_next = ST_BYP;
                            idx_next   = kvp_pkg::KEY_ADDR_W'(1);
                        end
                        kvp_pkg::CMD_STORED:
                        begin
                            ld      = 1'b1;
                            ld_kind = kvp_pkg::KIND_STORED;
                            ld_len  = '0;
                        end
                        default:
                        begin
                            ld      = 1'b1;
                            ld_kind = kvp_pkg::KIND_ERROR;
                            ld_len  = '0;
                        end
                    endcase
                end
            end
            ST_KEY:
            begin
                if (load_ok)
                begin
                    ld      = 1'b1;
                    ld_byte = rdata_reg;
                    ld_pres = 1'b1;
                    ld_last = key_last;
                    if (key_last)
                    begin
                        state_next = ST_IDLE;
                        key_done   = 1'b1;
                    end
                    else
                    begin
                        // fetch the following byte so it is ready next cycle
                        idx_next = idx_reg + 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            ST_BYP:
            begin
                if (load_ok)
                begin
                    ld      = 1'b1;
                    ld_pres = 1'b1;
                    ld_byte = (idx_reg == kvp_pkg::KEY_ADDR_W'(1)) ? kvp_pkg::CH_E :
                                                                     kvp_pkg::CH_Y;
                    ld_last = (idx_reg == kvp_pkg::KEY_ADDR_W'(2));
                    if (ld_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            if (load_ok)
            begin
                out_valid_reg <= ld;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            out_kind_reg <= ld_kind;
            out_byte_reg <= ld_byte;
            out_pres_reg <= ld_pres;
            out_len_reg  <= ld_len;
            out_last_reg <= ld_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_wr.en)
        begin
            key_mem[key_wr.addr] <= key_wr.data;
        end
        rdata_reg <= key_mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_len_reg, out_pres_reg, out_byte_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_key_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KEY) |-> (len_reg != '0))
        else $error("key reply with zero length");

    a_no_write_while_reading: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KEY) |-> !key_wr.en)
        else $error("key store written during key reply");
`endif

endmodule

// ===== rtl/kv_text_command_parser_core.sv =====
// Text key-value request parser. Request bytes enter on s_* one per transaction
// and replies leave on m_* as one item per key byte (VALUE) or a single item
// (STORED, ERROR, empty-key VALUE), tlast on the final item of each reply.
// Throughput is one byte per cycle, set by the line scanner in the front end.
// Exceptions: the byte after a CR that is not followed by LF stalls the input
// while it is held, since the CR and that byte are both scanned as line content;
// after a "get" line with a non-empty key the input stalls until the back end
// has streamed the key out of the key store, as both share that store; and the
// input also stalls while the four-entry reply queue is full.
// Configuration writes (index 0 bypass_parse, 1 value_length) are always
// taken and are meant for an idle block.
module kv_text_command_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // key_byte[7:0], key_present, reply_length[20:0]
    output logic [1:0]  m_tuser,   // reply_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [20:0] cfg_data
);

    logic                        bypass_reg;
    logic [kvp_pkg::VLEN_W-1:0]  vlen_reg;

    logic                        q_push;
    kvp_pkg::q_entry_t           q_push_data;
    logic                        q_full;
    logic                        q_pop;
    kvp_pkg::q_entry_t           q_pop_data;
    logic                        q_empty;
    kvp_pkg::key_wr_t            key_wr;
    logic                        key_done;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
            vlen_reg   <= kvp_pkg::VLEN_W'(32);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == kvp_pkg::REG_BYPASS)
            begin
                bypass_reg <= cfg_data[0];
            end
            else if (cfg_index == kvp_pkg::REG_VLEN)
            begin
                vlen_reg <= cfg_data;
            end
        end
    end

    kvp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .bypass      (bypass_reg),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .q_full      (q_full),
        .key_wr      (key_wr),
        .key_done    (key_done)
    );

    kvp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    kvp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_pop_data),
        .q_pop        (q_pop),
        .value_length (vlen_reg),
        .key_wr       (key_wr),
        .key_done     (key_done),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule

// ===== tb/kv_text_command_parser_core_test.sv =====
module kv_text_command_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kvp_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = KEY_MAX + 16;
    localparam longint unsigned SIZE_CAP = 64'd2147483647;
    // index with no register behind it; writes to it must be ignored
    localparam logic [3:0] REG_NONE = 4'd9;

    typedef enum logic [1:0] {SCAN_LINE, SCAN_SWALLOW, SCAN_DROP} scan_mode_t;
    typedef enum logic [1:0] {LN_NONE, LN_GET, LN_SET, LN_OTHER} line_cls_t;

    typedef struct packed {
        reply_kind_t kind;
        logic [7:0]  key;
        logic        present;
        logic [20:0] vlen;
        logic        last;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [20:0] cfg_data;

    kv_text_command_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5ns clk = ~clk;

    // parser mirror
    logic              p_bypass;
    logic [20:0]       p_vlen;
    scan_mode_t        p_mode;
    int                p_line_len;
    logic              p_cr;
    line_cls_t         p_cls;
    int                p_prefix;
    int                p_tok;
    logic [3:0]        p_tst;
    logic [7:0]        p_key [KEY_MAX];
    int                p_key_len;
    logic [31:0]       p_size;
    longint unsigned   p_swallow;

    reply_t fresh_replies[$];
    reply_t expected_replies[$];

    logic [7:0] line_buf[$];
    string      crlf = "\015\012";

    string      probe_text[$];
    bit         probe_typed[$];
    reply_t     probe_want[$];
    bit         typed_armed;
    reply_t     typed_reply;

    int mismatches;
    int bytes_sent;
    int lines_sent;
    int replies_due;
    int cfg_writes;
    int n_value;
    int n_stored;
    int n_error;
    int burst_left;
    int hold_request;
    int quiet_cycles;

    function automatic reply_t make_reply(reply_kind_t k, logic [7:0] kb, logic pres,
                                          logic [20:0] len, logic fin);
        reply_t r;
        r.kind = k;
        r.key = kb;
        r.present = pres;
        r.vlen = len;
        r.last = fin;
        return r;
    endfunction

    function automatic void emit(reply_kind_t k, logic [7:0] kb, logic pres,
                                 logic [20:0] len, logic fin);
        fresh_replies.push_back(make_reply(k, kb, pres, len, fin));
    endfunction

    function automatic void clear_scan();
        p_line_len = 0;
        p_cls = LN_NONE;
        p_prefix = 0;
        p_tok = 0;
        p_tst = 4'd0;
        p_key_len = 0;
        p_size = 32'd0;
    endfunction

    function automatic void reset_model();
        p_bypass = 1'b0;
        p_vlen = 21'd32;
        p_mode = SCAN_LINE;
        p_cr = 1'b0;
        p_swallow = 0;
        clear_scan();
    endfunction

    function automatic bit is_space(logic [7:0] b);
        return b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_VT || b == CH_FF
            || b == CH_CR;
    endfunction

    function automatic void scan_get(logic [7:0] b);
        case (p_tst)
            4'd0: if (b == CH_SP) p_tst = 4'd1;
            4'd1, 4'd2:
            begin
                if (b == CH_SP)
                    p_tst = 4'd3;
                else
                begin
                    p_tst = 4'd2;
                    if (p_key_len < KEY_MAX)
                    begin
                        p_key[p_key_len] = b;
                        p_key_len++;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // p_tst: [1:0] sub-state (skip, word, sign, digits), [2] minus, [3] overflow.
    // p_tok 5 = size complete, 6 = scan failed.
    function automatic void scan_set(logic [7:0] b);
        logic [1:0]      sub;
        bit              dig;
        longint unsigned v;
        for (int pass = 0; pass < 2; pass++)
        begin
            sub = p_tst[1:0];
            dig = (b >= CH_0 && b <= CH_9);
            if (p_tok >= 5)
                return;
            if (p_tok < 2)
            begin
                if (sub == 2'd0)
                begin
                    if (!is_space(b))
                        p_tst = 4'd1;
                end
                else if (is_space(b))
                begin
                    p_tok++;
                    p_tst = 4'd0;
                end
                return;
            end
            if (sub == 2'd3 && !dig)
            begin
                // integer ends here; the same byte may start the next one
                p_tok++;
                p_tst = 4'd0;
                if (p_tok >= 5)
                    return;
                continue;
            end
            if (sub == 2'd0)
            begin
                if (is_space(b))
                    return;
                if (b == CH_PLUS || b == CH_MINUS)
                begin
                    p_tst = (b == CH_MINUS) ? 4'd6 : 4'd2;
                    return;
                end
                if (!dig)
                begin
                    p_tok = 6;
                    return;
                end
            end
            else if (sub == 2'd2 && !dig)
            begin
                p_tok = 6;
                return;
            end
            p_tst = (p_tst & 4'hC) | 4'h3;
            if (p_tok == 4 && !p_tst[3])
            begin
                v = 64'(p_size) * 10 + 64'(b - CH_0);
                if (v > SIZE_CAP)
                    p_tst[3] = 1'b1;
                else
                    p_size = v[31:0];
            end
            return;
        end
    endfunction

    function automatic void commit_byte(logic [7:0] b);
        int         pos;
        logic [7:0] c;
        if (p_mode != SCAN_LINE)
            return;
        if (p_line_len >= LINE_MAX)
        begin
            p_mode = SCAN_DROP;
            return;
        end
        pos = p_line_len;
        p_line_len++;
        if (pos < 3 && p_cls != LN_OTHER)
        begin
            c = (b >= CH_UA && b <= CH_UZ) ? b + 8'h20 : b;
            if (pos == 0)
                p_cls = (c == CH_G) ? LN_GET : (c == CH_S) ? LN_SET : LN_OTHER;
            else if (c != ((pos == 1) ? CH_E : CH_T))
                p_cls = LN_OTHER;
            if (p_cls != LN_OTHER)
                p_prefix++;
        end
        if (p_cls == LN_GET)
            scan_get(b);
        else if (p_cls == LN_SET)
            scan_set(b);
    endfunction

    function automatic void finish_line();
        if (p_prefix == 3 && p_cls == LN_GET && p_tst >= 4'd2)
        begin
            if (p_key_len == 0)
                emit(KIND_VALUE, 8'h00, 1'b0, p_vlen, 1'b1);
            else
                for (int i = 0; i < p_key_len; i++)
                    emit(KIND_VALUE, p_key[i], 1'b1, p_vlen, i + 1 == p_key_len);
        end
        else if (p_prefix == 3 && p_cls == LN_SET
                 && (p_tok == 5 || (p_tok == 4 && p_tst[1:0] == 2'd3))
                 && !p_tst[3] && (!p_tst[2] || p_size == 32'd0))
        begin
            p_swallow = 64'(p_size) + 2;
            p_mode = SCAN_SWALLOW;
        end
        else
            emit(KIND_ERROR, 8'h00, 1'b0, 21'd0, 1'b1);
        clear_scan();
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        if (p_bypass)
        begin
            clear_scan();
            if (p_cr && b == CH_LF)
            begin
                p_cr = 1'b0;
                emit(KIND_VALUE, CH_K, 1'b1, p_vlen, 1'b0);
                emit(KIND_VALUE, CH_E, 1'b1, p_vlen, 1'b0);
                emit(KIND_VALUE, CH_Y, 1'b1, p_vlen, 1'b1);
                return;
            end
            p_cr = (b == CH_CR);
            return;
        end
        if (p_mode == SCAN_SWALLOW)
        begin
            p_cr = 1'b0;
            if (p_swallow > 1)
            begin
                p_swallow--;
                return;
            end
            p_swallow = 0;
            p_mode = SCAN_LINE;
            clear_scan();
            emit(KIND_STORED, 8'h00, 1'b0, 21'd0, 1'b1);
            return;
        end
        if (p_cr)
        begin
            if (b == CH_LF)
            begin
                p_cr = 1'b0;
                if (p_mode == SCAN_DROP)
                begin
                    p_mode = SCAN_LINE;
                    clear_scan();
                end
                else
                    finish_line();
                return;
            end
            commit_byte(CH_CR);
        end
        if (b == CH_CR)
            p_cr = 1'b1;
        else
        begin
            p_cr = 1'b0;
            commit_byte(b);
        end
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // reply checker
    always @(posedge clk)
    begin : check_reply
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            case (m_tuser)
                KIND_VALUE: n_value++;
                KIND_STORED: n_stored++;
                default: n_error++;
            endcase
            if (expected_replies.size() == 0)
                flag_mismatch($sformatf("unexpected reply kind %0d key %02h",
                                        m_tuser, m_tdata[7:0]));
            else
            begin
                want = expected_replies.pop_front();
                if (m_tuser !== want.kind)
                    flag_mismatch($sformatf("reply_kind %0d, want %0d", m_tuser, want.kind));
                if (m_tdata[7:0] !== want.key)
                    flag_mismatch($sformatf("key_byte %02h, want %02h", m_tdata[7:0], want.key));
                if (m_tdata[8] !== want.present)
                    flag_mismatch($sformatf("key_present %b, want %b", m_tdata[8], want.present));
                if (m_tdata[29:9] !== want.vlen)
                    flag_mismatch($sformatf("reply_length %0d, want %0d",
                                            m_tdata[29:9], want.vlen));
                if (m_tlast !== want.last)
                    flag_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
                if (m_tdata[31:30] !== 2'b00)
                    flag_mismatch($sformatf("tdata pad bits %b", m_tdata[31:30]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("watchdog: no transaction for %0d cycles, %0d replies outstanding",
                             quiet_cycles, expected_replies.size());
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    // reply side: changing stall style, plus an occasional long hold-off
    initial
    begin : rx_side
        int tick;
        int held;
        int style;
        tick = 0;
        held = 0;
        style = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick % 64 == 0)
                style = $urandom_range(0, 2);
            if (hold_request > 0)
            begin
                held = hold_request;
                hold_request = 0;
            end
            if (held > 0)
            begin
                held--;
                m_tready <= 1'b0;
            end
            else
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= (tick % 9) >= 3;
                endcase
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        bytes_sent++;
        parse_byte(b);
        if (fresh_replies.size() != 0)
        begin
            if (typed_armed)
            begin
                expected_replies.push_back(typed_reply);
                fresh_replies.delete();
            end
            while (fresh_replies.size() != 0)
                expected_replies.push_back(fresh_replies.pop_front());
            replies_due++;
        end
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [20:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_BYPASS)
            p_bypass = data[0];
        else if (idx == REG_VLEN)
            p_vlen = data;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop offering, let every reply come back, then leave room for a key stream
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // '~' stands for a NUL byte, which a string cannot carry
    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back((s[i] == "~") ? 8'h00 : s[i]);
    endfunction

    function automatic void put_cased(string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if ($urandom_range(0, 1))
                c = c - 8'h20;
            line_buf.push_back(c);
        end
    endfunction

    function automatic void put_gap();
        case ($urandom_range(0, 7))
            0: line_buf.push_back(CH_TAB);
            1: put_text("  ");
            2: line_buf.push_back($urandom_range(0, 1) ? CH_VT : CH_FF);
            default: line_buf.push_back(CH_SP);
        endcase
    endfunction

    function automatic void put_word();
        repeat ($urandom_range(1, 5))
            line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
    endfunction

    function automatic void put_number(int lo, int hi);
        put_text($sformatf("%0d", $urandom_range(lo, hi)));
    endfunction

    task automatic send_line_buf();
        for (int i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i]);
        line_buf.delete();
        lines_sent++;
    endtask

    function automatic void build_get();
        int         klen;
        logic [7:0] c;
        put_cased("get");
        line_buf.push_back(CH_SP);
        klen = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
        if (klen == 0)
            line_buf.push_back(CH_SP);
        repeat (klen)
        begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_SP || c == CH_CR);
            line_buf.push_back(c);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            line_buf.push_back(CH_SP);
            put_word();
        end
        put_text(crlf);
    endfunction

    function automatic void build_set(bit broken);
        put_cased("set");
        put_gap();
        put_word();
        put_gap();
        if (broken && $urandom_range(0, 4) == 0)
            put_text("x1");
        else
            put_number(0, 999);
        put_gap();
        put_number(0, 99999);
        if (!broken || $urandom_range(0, 3) != 0)
            put_gap();
        if (!broken)
            case ($urandom_range(0, 5))
                0: put_text("-0");
                1: begin put_text("+"); put_number(0, 24); end
                default: put_number(0, 24);
            endcase
        else
            case ($urandom_range(0, 3))
                0: begin put_text("-"); put_number(1, 9); end
                1: put_text($sformatf("%0d%0d", $urandom_range(3, 9), $urandom_range(0, 999999999)));
                2: put_text($urandom_range(0, 1) ? "q" : "+x");
                default: begin put_number(0, 9); put_word(); end
            endcase
        put_text(crlf);
    endfunction

    function automatic void build_noise();
        repeat ($urandom_range(0, 10))
            line_buf.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0)
        begin
            line_buf.push_back(CH_CR);
            line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
        put_text(crlf);
    endfunction

    task automatic send_random_line();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            build_get();
        else if (pick < 70)
            build_set(1'b0);
        else if (pick < 85)
            build_set(1'b1);
        else
            build_noise();
        send_line_buf();
        // data block of an accepted set
        while (!p_bypass && p_mode == SCAN_SWALLOW)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(input int min_bytes, input int min_replies);
        int start_bytes;
        int start_replies;
        start_bytes = bytes_sent;
        start_replies = replies_due;
        while (bytes_sent - start_bytes < min_bytes || replies_due - start_replies < min_replies)
            send_random_line();
    endtask

    function automatic void add_probe(string text, bit typed, reply_t want);
        probe_text.push_back(text);
        probe_typed.push_back(typed);
        probe_want.push_back(want);
    endfunction

    initial
    begin
        reply_t err;
        reply_t none;
        string  long_key;
        string  filler;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = REG_BYPASS;
        cfg_data = 21'd0;
        mismatches = 0;
        bytes_sent = 0;
        lines_sent = 0;
        replies_due = 0;
        cfg_writes = 0;
        n_value = 0;
        n_stored = 0;
        n_error = 0;
        burst_left = 0;
        hold_request = 0;
        quiet_cycles = 0;
        typed_armed = 1'b0;
        reset_model();

        err = make_reply(KIND_ERROR, 8'h00, 1'b0, 21'd0, 1'b1);
        none = err;
        long_key = "";
        for (int i = 0; i < 70; i++)
            long_key = {long_key, $sformatf("%c", 8'h30 + i)};
        filler = "";
        for (int i = 0; i < LINE_MAX + 6; i++)
            filler = {filler, "x"};

        add_probe({"get k", crlf}, 1'b1, make_reply(KIND_VALUE, CH_K, 1'b1, 21'd32, 1'b1));
        add_probe({"G\377~", crlf}, 1'b1, err);
        add_probe({"gEt  ", crlf}, 1'b1, make_reply(KIND_VALUE, 8'h00, 1'b0, 21'd32, 1'b1));
        add_probe({"get", crlf}, 1'b1, err);
        add_probe({"get ", crlf}, 1'b1, err);
        add_probe({"GET ab cd", crlf}, 1'b0, none);
        add_probe({"get ", long_key, crlf}, 1'b0, none);
        add_probe({"s\015x\015", crlf}, 1'b0, none);
        add_probe({"\012", crlf}, 1'b0, none);
        add_probe({"set k 1 2 3", crlf, "xyz", crlf}, 1'b0, none);
        add_probe({"SET k 0 0 -0", crlf, crlf}, 1'b0, none);
        add_probe({"set\011k\013+1\014-2 +0", crlf, crlf}, 1'b0, none);
        add_probe({"set k 0 0 -5", crlf}, 1'b1, err);
        add_probe({"set k 0 0 4294967296", crlf}, 1'b1, err);
        add_probe({"set k x 0 1", crlf}, 1'b1, err);
        add_probe({"set k 0 0", crlf}, 1'b1, err);
        add_probe({"sex", crlf}, 1'b1, err);
        // overlong line is dropped silently, the next line must parse again
        add_probe({"get ", filler, crlf, "get z", crlf}, 1'b0, none);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < probe_text.size(); i++)
        begin
            typed_armed = probe_typed[i];
            typed_reply = probe_want[i];
            put_text(probe_text[i]);
            send_line_buf();
        end
        typed_armed = 1'b0;
        settle();

        write_reg(REG_VLEN, 21'h100000);
        write_reg(REG_NONE, 21'($urandom_range(0, 21'h1FFFFF)));
        run_phase(50, 15);
        settle();

        write_reg(REG_BYPASS, 21'd1);
        write_reg(REG_VLEN, 21'd0);
        run_phase(40, 12);
        settle();

        // bypass takes bit 0 only
        write_reg(REG_BYPASS, 21'h1FFFFE);
        write_reg(REG_VLEN, 21'($urandom_range(0, 1048576)));
        hold_request = HOLD_CYCLES;
        run_phase(50, 15);
        settle();

        write_reg(REG_VLEN, 21'd32);
        run_phase(50, 15);
        settle();

        $display("covered %0d request bytes in %0d lines and %0d register writes",
                 bytes_sent, lines_sent, cfg_writes);
        $display("checked %0d reply items: %0d VALUE, %0d STORED, %0d ERROR; %0d mismatches",
                 n_value + n_stored + n_error, n_value, n_stored, n_error, mismatches);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/kvp_pkg.sv
rtl/kvp_fifo.sv
rtl/kvp_front.sv
rtl/kvp_back.sv
rtl/kv_text_command_parser_core.sv
tb/kv_text_command_parser_core_test.sv
